// File: src/dhrwp_pkg.sv
package dhrwp_pkg;

  localparam int unsigned AdcW = 12;

  // readout flag codes
  localparam logic [2:0] FLAG_RPC   = 3'd2;
  localparam logic [2:0] FLAG_SCINT = 3'd4;

  // board numbers
  localparam logic [2:0] BOARD_FWD_MID   = 3'd1;
  localparam logic [2:0] BOARD_FWD_OUTER = 3'd2;
  localparam logic [2:0] BOARD_BWD_MID   = 3'd3;
  localparam logic [2:0] BOARD_BWD_OUTER = 3'd4;

  // per-layer/plane strip maxima used for the flip
  localparam logic signed [7:0] MAXC_S3_SCINT = 8'sd38;
  localparam logic signed [7:0] MAXC_S3_RPC   = 8'sd34;
  localparam logic signed [7:0] MAXC_PHI_L1   = 8'sd37;
  localparam logic signed [7:0] MAXC_PHI_L2   = 8'sd42;
  localparam logic signed [7:0] MAXC_PHI_IN   = 8'sd36;
  localparam logic signed [7:0] MAXC_OUTER    = 8'sd48;
  localparam logic signed [7:0] MAXC_Z_SCINT  = 8'sd54;

  typedef struct packed {
    logic        is_forward;
    logic [3:0]  sector;
    logic [3:0]  layer;
    logic        plane;
    logic [5:0]  strip;
    logic [10:0] hit_time;
    logic [11:0] hit_charge;
    logic [15:0] coarse_time;
    logic        is_rpc;
  } hit_t;

  typedef struct packed {
    logic [2:0]  board_index;
    logic [1:0]  link_index;
    logic [31:0] first_word;
    logic [31:0] second_word;
  } word_t;

  typedef struct packed {
    logic  hit;
    word_t word;
  } map_res_t;

endpackage

// File: src/dhrwp_map.sv
module dhrwp_map
  import dhrwp_pkg::*;
(
  input  hit_t             hit_i,
  input  logic [AdcW-1:0]  adc_offset_i,
  output map_res_t         res_o
);

  logic              mid, outer, keep, s3_bwd;
  logic [2:0]        board;
  logic [1:0]        link;
  logic [4:0]        lane;
  logic              axis;
  logic signed [7:0] maxc;
  logic signed [7:0] strip_s;
  logic signed [7:0] ch_flip;
  logic signed [7:0] ch;
  logic [2:0]        flag;
  logic [11:0]       charge;
  logic              lay_hi, lay_l1, lay_l2;

  assign lay_hi = hit_i.layer > 4'd2;
  assign lay_l1 = hit_i.layer == 4'd1;
  assign lay_l2 = hit_i.layer == 4'd2;
  assign mid    = hit_i.sector >= 4'd3 && hit_i.sector <= 4'd6;
  assign outer  = hit_i.sector == 4'd1 || hit_i.sector == 4'd2 ||
                  hit_i.sector == 4'd7 || hit_i.sector == 4'd8;
  assign s3_bwd = !hit_i.is_forward && hit_i.sector == 4'd3;

  always_comb begin
    if (hit_i.is_forward) begin
      board = mid ? BOARD_FWD_MID : BOARD_FWD_OUTER;
    end else begin
      board = mid ? BOARD_BWD_MID : BOARD_BWD_OUTER;
    end
    if (mid) begin
      link = 2'(hit_i.sector - 4'd3);
    end else if (hit_i.sector <= 4'd2) begin
      link = 2'(hit_i.sector + 4'd1);
    end else begin
      link = 2'(hit_i.sector - 4'd7);
    end
  end

  assign lane = lay_hi ? 5'(hit_i.layer) + 5'd5 : {1'b0, hit_i.layer};
  assign axis = lay_hi ? hit_i.plane : !hit_i.plane;

  always_comb begin
    maxc = 8'sd0;
    if (s3_bwd && !hit_i.plane) begin
      maxc = (hit_i.layer < 4'd3) ? MAXC_S3_SCINT : MAXC_S3_RPC;
    end else if (hit_i.plane) begin
      priority if (lay_l1) maxc = MAXC_PHI_L1;
      else if (lay_l2) maxc = MAXC_PHI_L2;
      else if (lay_hi && hit_i.layer < 4'd7) maxc = MAXC_PHI_IN;
      else if (hit_i.layer > 4'd6) maxc = MAXC_OUTER;
      else maxc = 8'sd0;
    end else begin
      priority if (lay_l1 || lay_l2) maxc = MAXC_Z_SCINT;
      else if (lay_hi) maxc = MAXC_OUTER;
      else maxc = 8'sd0;
    end
  end

  // forward outer sectors and backward 4..7 keep phi strips of outer layers unflipped
  assign keep = (hit_i.is_forward && outer) ||
                (!hit_i.is_forward && hit_i.sector >= 4'd4 && hit_i.sector <= 4'd7);

  assign strip_s = $signed({2'b00, hit_i.strip});
  assign ch_flip = (keep && lay_hi && hit_i.plane) ? strip_s : maxc - strip_s + 8'sd1;

  always_comb begin
    ch = ch_flip;
    if (hit_i.plane) begin
      if (lay_l1) begin
        ch = ch_flip + 8'sd4;
      end else if (lay_l2) begin
        ch = ch_flip + 8'sd2;
      end
    end else if (hit_i.layer < 4'd3) begin
      if (s3_bwd) begin
        if (lay_l1) begin
          if (ch_flip > 8'sd0 && ch_flip < 8'sd9) ch = 8'sd9 - ch_flip;
          else if (ch_flip > 8'sd8 && ch_flip < 8'sd39) ch = 8'sd54 - ch_flip;
        end else begin
          if (ch_flip > 8'sd0 && ch_flip < 8'sd10) ch = 8'sd10 - ch_flip;
          else if (ch_flip > 8'sd9 && ch_flip < 8'sd24) ch = 8'sd40 - ch_flip;
          else if (ch_flip > 8'sd23 && ch_flip < 8'sd39) ch = 8'sd69 - ch_flip;
        end
      end else begin
        if (ch_flip > 8'sd0 && ch_flip < 8'sd10) ch = 8'sd10 - ch_flip;
        else if (ch_flip > 8'sd9 && ch_flip < 8'sd25) ch = 8'sd40 - ch_flip;
        else if (ch_flip > 8'sd24 && ch_flip < 8'sd40) ch = 8'sd70 - ch_flip;
        else if (ch_flip > 8'sd39 && ch_flip < 8'sd55) ch = 8'sd100 - ch_flip;
      end
    end
  end

  assign flag   = hit_i.is_rpc ? FLAG_RPC : FLAG_SCINT;
  assign charge = adc_offset_i - hit_i.hit_charge;

  always_comb begin
    res_o.hit              = mid || outer;
    res_o.word.board_index = board;
    res_o.word.link_index  = link;
    res_o.word.first_word  = {flag, lane, axis, 1'b0, ch[5:0], hit_i.coarse_time};
    res_o.word.second_word = {5'b0, hit_i.hit_time, 4'b0, charge};
  end

endmodule

// File: src/detector_hit_readout_word_packer_core.sv
// Hit readout word packer. Each hit beat is registered, mapped from detector
// geometry (end, sector, layer, plane, strip) to board, link, lane, axis and
// channel in one pass of shallow logic, and the two packed readout words land
// in an output register. One hit per clock is sustained while the receiver
// does not hold out_stall. Hits whose sector maps to no board
// are dropped silently. adc_offset (cfg_wr_data) sets the charge pedestal and
// should only be written while no hit is in flight.
module detector_hit_readout_word_packer_core
  import dhrwp_pkg::*;
(
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_stall,
  input  hit_t            in_data,
  output logic            out_valid,
  input  logic            out_stall,
  output word_t           out_data,
  input  logic            cfg_wr_en,
  input  logic [AdcW-1:0] cfg_wr_data
);

  logic            s1_valid_r, s1_valid_nxt;
  hit_t            s1_hit_r;
  logic            out_valid_r, out_valid_nxt;
  word_t           out_word_r;
  logic [AdcW-1:0] adc_offset_r;
  logic            out_busy;
  map_res_t        map_res;

  assign out_busy = out_valid_r && out_stall;
  assign in_stall = s1_valid_r && out_busy;

  dhrwp_map u_map (
    .hit_i        (s1_hit_r),
    .adc_offset_i (adc_offset_r),
    .res_o        (map_res)
  );

  always_comb begin
    s1_valid_nxt  = in_stall ? s1_valid_r : in_valid;
    out_valid_nxt = out_busy ? out_valid_r : (s1_valid_r && map_res.hit);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r   <= 1'b0;
      out_valid_r  <= 1'b0;
      adc_offset_r <= '0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) begin
        adc_offset_r <= cfg_wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall) begin
      s1_hit_r <= in_data;
    end
    if (!out_busy) begin
      out_word_r <= map_res.word;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_word_r;

  // a hit with no board never reaches the output
  a_drop_unmapped: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && !out_busy && !map_res.hit |=> !out_valid_r)
    else $error("unmapped hit produced a result beat");

  a_board_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_word_r.board_index != 3'd0 && out_word_r.board_index <= 3'd4))
    else $error("result board out of range");

  a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |=> s1_valid_r && $stable(s1_hit_r))
    else $error("input stage lost a stalled hit");

endmodule

// File: sim/testbench.sv
`timescale 1ns / 100ps

module testbench;
  import dhrwp_pkg::*;

  localparam int LIMIT = 300000;
  localparam int PHASE_HITS = 176;

  typedef struct {
    hit_t  hit;
    bit    typed;    // expected word typed in by hand
    bit    has_res;
    word_t exp;
  } row_t;

  typedef enum logic [1:0] {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_TOGGLE} stall_mode_t;

  logic            clk = 1'b0;
  logic            rst_n = 1'b0;
  logic            in_valid = 1'b0;
  logic            in_stall;
  hit_t            in_data = '0;
  logic            out_valid;
  logic            out_stall = 1'b0;
  word_t           out_data;
  logic            cfg_wr_en = 1'b0;
  logic [AdcW-1:0] cfg_wr_data = '0;

  // sideband that travels with the current input beat
  logic  row_typed = 1'b0;
  logic  row_has = 1'b0;
  word_t row_word = '0;

  word_t       words_due[$];
  row_t        hit_table[$];
  logic [11:0] pedestal = '0;
  int          mismatches = 0;
  int          cycles = 0;
  int          burst_left = 0;
  int          mode_left = 0;
  stall_mode_t stall_mode = STALL_NONE;
  word_t       due_w;
  word_t       pred_w;

  detector_hit_readout_word_packer_core DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [5:0] strip_channel(hit_t h);
    int maxc;
    int ch;
    int lyr;
    int sec;
    bit keep;
    maxc = 0;
    lyr = int'(h.layer);
    sec = int'(h.sector);
    ch = int'(h.strip);
    if (!h.is_forward && sec == 3 && !h.plane) begin
      maxc = (lyr < 3) ? MAXC_S3_SCINT : MAXC_S3_RPC;
    end else if (h.plane) begin
      if (lyr == 1) maxc = MAXC_PHI_L1;
      else if (lyr == 2) maxc = MAXC_PHI_L2;
      else if (lyr > 2 && lyr < 7) maxc = MAXC_PHI_IN;
      else if (lyr > 6) maxc = MAXC_OUTER;
    end else begin
      if (lyr == 1 || lyr == 2) maxc = MAXC_Z_SCINT;
      else if (lyr > 2) maxc = MAXC_OUTER;
    end
    // phi strips of outer layers in these sectors run the same way as the channels
    keep = (h.is_forward && (sec == 1 || sec == 2 || sec == 7 || sec == 8)) ||
           (!h.is_forward && sec >= 4 && sec <= 7);
    if (!(keep && lyr > 2 && h.plane)) ch = maxc - ch + 1;
    if (h.plane) begin
      if (lyr == 1) ch += 4;
      else if (lyr == 2) ch += 2;
    end else if (lyr < 3) begin
      if (!h.is_forward && sec == 3) begin
        if (lyr == 1) begin
          if (ch > 0 && ch < 9) ch = 9 - ch;
          else if (ch > 8 && ch < 39) ch = 54 - ch;
        end else begin
          if (ch > 0 && ch < 10) ch = 10 - ch;
          else if (ch > 9 && ch < 24) ch = 40 - ch;
          else if (ch > 23 && ch < 39) ch = 69 - ch;
        end
      end else begin
        if (ch > 0 && ch < 10) ch = 10 - ch;
        else if (ch > 9 && ch < 25) ch = 40 - ch;
        else if (ch > 24 && ch < 40) ch = 70 - ch;
        else if (ch > 39 && ch < 55) ch = 100 - ch;
      end
    end
    return ch[5:0];
  endfunction

  function automatic bit pack_hit(input hit_t h, input logic [11:0] ped, output word_t w);
    logic [2:0] flag;
    logic [4:0] lane;
    logic       axis;
    int         sec;
    bit         mid;
    bit         outer;
    w = '0;
    sec = int'(h.sector);
    mid = sec >= 3 && sec <= 6;
    outer = sec == 1 || sec == 2 || sec == 7 || sec == 8;
    if (!mid && !outer) return 1'b0;
    w.board_index = h.is_forward ? (mid ? BOARD_FWD_MID : BOARD_FWD_OUTER)
                                 : (mid ? BOARD_BWD_MID : BOARD_BWD_OUTER);
    if (mid) w.link_index = 2'(sec - 3);
    else if (sec <= 2) w.link_index = 2'(sec + 1);
    else w.link_index = 2'(sec - 7);
    lane = (h.layer > 2) ? 5'(h.layer + 5) : 5'(h.layer);
    axis = (h.layer > 2) ? h.plane : ~h.plane;
    flag = h.is_rpc ? FLAG_RPC : FLAG_SCINT;
    w.first_word = {flag, lane, axis, 1'b0, strip_channel(h), h.coarse_time};
    w.second_word = {5'b0, h.hit_time, 4'b0, 12'(ped - h.hit_charge)};
    return 1'b1;
  endfunction

  function automatic hit_t mk_hit(int fwd, int sec, int lyr, int pl, int strp,
                                  int tm, int chg, int ct, int rpc);
    hit_t h;
    h.is_forward = 1'(fwd);
    h.sector = 4'(sec);
    h.layer = 4'(lyr);
    h.plane = 1'(pl);
    h.strip = 6'(strp);
    h.hit_time = 11'(tm);
    h.hit_charge = 12'(chg);
    h.coarse_time = 16'(ct);
    h.is_rpc = 1'(rpc);
    return h;
  endfunction

  function automatic hit_t rand_hit();
    hit_t h;
    int   sel;
    h = hit_t'($bits(hit_t)'({$urandom, $urandom}));
    sel = $urandom_range(0, 99);
    if (sel < 6) begin
      h.sector = 4'($urandom_range(9, 16));  // 16 wraps to sector 0
    end else if (sel < 22) begin
      h.is_forward = 1'b0;
      h.sector = 4'd3;
    end else begin
      h.sector = 4'($urandom_range(1, 8));
    end
    sel = $urandom_range(0, 99);
    if (sel < 40) h.layer = 4'($urandom_range(1, 2));
    else if (sel < 43) h.layer = 4'd0;
    else h.layer = 4'($urandom_range(3, 15));
    return h;
  endfunction

  task automatic add_row(input hit_t h);
    row_t r;
    r.hit = h;
    r.typed = 1'b0;
    r.has_res = 1'b0;
    r.exp = '0;
    hit_table = {hit_table, r};
  endtask

  task automatic add_known(input hit_t h, input bit has_res, input word_t w);
    row_t r;
    r.hit = h;
    r.typed = 1'b1;
    r.has_res = has_res;
    r.exp = w;
    hit_table = {hit_table, r};
  endtask

  // called at a rising edge, returns at the edge that takes the beat
  task automatic send_row(input row_t r);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 12);
    end
    burst_left--;
    in_data <= r.hit;
    row_typed <= r.typed;
    row_has <= r.has_res;
    row_word <= r.exp;
    in_valid <= 1'b1;
    do @(negedge clk); while (in_stall);
    @(posedge clk);
  endtask

  task automatic set_pedestal(input logic [11:0] v);
    in_valid <= 1'b0;
    while (words_due.size() != 0) @(posedge clk);
    // dropped hits may still be in the pipe
    repeat (4) @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic check_field(input string tag, input logic [31:0] exp_v, input logic [31:0] act_v);
    if (act_v !== exp_v) begin
      $display("%0t: %s mismatch, expected %h, got %h", $time, tag, exp_v, act_v);
      mismatches++;
    end
  endtask

  // receiver stall pattern
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      mode_left = 0;
    end else begin
      if (mode_left == 0) begin
        stall_mode = stall_mode_t'($urandom_range(0, 3));
        mode_left = $urandom_range(8, 80);
      end
      mode_left--;
      case (stall_mode)
        STALL_NONE:  out_stall <= 1'b0;
        STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
        STALL_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
        default:     out_stall <= ~out_stall;
      endcase
    end
  end

  // signals are stable at the falling edge; beats complete at the next rising edge
  always @(negedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        if (row_typed) begin
          if (row_has) words_due = {words_due, row_word};
        end else if (pack_hit(in_data, pedestal, pred_w)) begin
          words_due = {words_due, pred_w};
        end
      end
      if (cfg_wr_en) pedestal = cfg_wr_data;
      if (out_valid && !out_stall) begin
        if (words_due.size() == 0) begin
          $display("%0t: result beat with none expected, got %h", $time, out_data);
          mismatches++;
        end else begin
          due_w = words_due.pop_front();
          check_field("board_index", 32'(due_w.board_index), 32'(out_data.board_index));
          check_field("link_index", 32'(due_w.link_index), 32'(out_data.link_index));
          check_field("first_word", due_w.first_word, out_data.first_word);
          check_field("second_word", due_w.second_word, out_data.second_word);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin : stim
    int          mapped;
    row_t        r;
    logic [11:0] peds[6];
    peds = '{12'hFFF, 12'($urandom), 12'h000, 12'h001, 12'($urandom), 12'h800};

    // pedestal is 0 out of reset
    add_known(mk_hit(1, 1, 3, 1, 5, 0, 0, 0, 1), 1'b1,
              word_t'{BOARD_FWD_OUTER, 2'd2, 32'h4885_0000, 32'h0000_0000});
    add_known(mk_hit(0, 4, 15, 1, 63, 2047, 4095, 16'hFFFF, 0), 1'b1,
              word_t'{BOARD_BWD_MID, 2'd1, 32'h94BF_FFFF, 32'h07FF_0001});
    add_known(mk_hit(1, 8, 4, 1, 1, 0, 0, 0, 1), 1'b1,
              word_t'{BOARD_FWD_OUTER, 2'd1, 32'h4981_0000, 32'h0000_0000});
    add_known(mk_hit(1, 0, 1, 0, 10, 100, 5, 7, 0), 1'b0, '0);
    add_known(mk_hit(0, 9, 2, 1, 20, 2047, 4095, 16'hFFFF, 1), 1'b0, '0);
    add_known(mk_hit(1, 15, 15, 1, 63, 2047, 4095, 16'hFFFF, 1), 1'b0, '0);
    add_row(mk_hit(1, 3, 1, 1, 10, 1, 1, 1, 0));
    add_row(mk_hit(1, 5, 2, 1, 42, 1024, 2048, 16'h8000, 1));
    add_row(mk_hit(0, 3, 1, 0, 5, 3, 9, 16'h1234, 0));
    add_row(mk_hit(0, 3, 1, 0, 35, 5, 4000, 16'h5555, 0));
    add_row(mk_hit(0, 3, 2, 0, 20, 7, 0, 16'hAAAA, 0));
    add_row(mk_hit(0, 3, 2, 0, 1, 11, 1, 16'h0F0F, 1));
    add_row(mk_hit(0, 3, 2, 0, 35, 13, 77, 16'hF0F0, 0));
    add_row(mk_hit(1, 2, 1, 0, 54, 17, 300, 2, 0));
    add_row(mk_hit(1, 2, 2, 0, 20, 19, 301, 3, 0));
    add_row(mk_hit(0, 8, 1, 0, 1, 23, 302, 4, 0));
    add_row(mk_hit(0, 8, 2, 0, 40, 29, 303, 5, 0));
    add_row(mk_hit(0, 6, 0, 0, 1, 31, 304, 6, 1));   // layer zero, z strips
    add_row(mk_hit(1, 4, 0, 1, 63, 37, 305, 7, 1));  // layer zero, phi strips
    add_row(mk_hit(0, 3, 5, 0, 34, 41, 306, 8, 1));
    add_row(mk_hit(1, 6, 7, 1, 48, 43, 307, 9, 1));
    add_row(mk_hit(0, 1, 9, 0, 63, 47, 308, 10, 1)); // flip goes negative, wraps
    add_row(mk_hit(1, 7, 3, 1, 0, 53, 309, 11, 0));
    add_row(mk_hit(0, 2, 6, 1, 36, 59, 310, 12, 0));

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (hit_table[i]) send_row(hit_table[i]);

    foreach (peds[p]) begin
      set_pedestal(peds[p]);
      mapped = 0;
      while (mapped < PHASE_HITS) begin
        r.hit = rand_hit();
        r.typed = 1'b0;
        r.has_res = 1'b0;
        r.exp = '0;
        if (r.hit.sector >= 1 && r.hit.sector <= 8) mapped++;
        send_row(r);
      end
    end

    in_valid <= 1'b0;
    while (words_due.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// File: files.f
src/dhrwp_pkg.sv
src/dhrwp_map.sv
src/detector_hit_readout_word_packer_core.sv
sim/testbench.sv
